// ----- rtl/core/octant_masked_circle_rasterizer_unit_defines.svh -----
// Assertion macros for the octant masked circle rasterizer.
// Included by files that check properties; needs clk_i and rst_ni in scope.
`ifndef OCTANT_MASKED_CIRCLE_RASTERIZER_UNIT_DEFINES_SVH
`define OCTANT_MASKED_CIRCLE_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define OMCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("omcr: same-cycle property violated");

// Next-cycle implication, sampled on clk_i, off during reset.
`define OMCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("omcr: next-cycle property violated");

`endif

// ----- rtl/core/omcr_pkg.sv -----
// Package for the octant masked circle rasterizer: field widths, codes,
// decision constants and the per-octant color and sign tables. No dependencies.
package omcr_pkg;

  localparam int unsigned COORD_BITS = 10;

  localparam int unsigned STEP_W   = 10;
  localparam int unsigned DEC_W    = 14;
  localparam int unsigned CENTER_W = 10;
  localparam int unsigned RADIUS_W = 9;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned PIX_W    = 12;
  localparam int unsigned OCT_W    = 3;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 12'd300;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 12'd300;

  localparam logic [DEC_W-1:0] DEC_INIT    = 14'd3;
  localparam logic [DEC_W-1:0] DEC_ADD_POS = 14'd10;
  localparam logic [DEC_W-1:0] DEC_ADD_NEG = 14'd6;

  // Octants 4..7 use y for the column offset and x for the row offset.
  // Bit k set: octant k subtracts that offset from the center.
  localparam logic [MASK_W-1:0] OCT_NEG_X = 8'b0011_1010;
  localparam logic [MASK_W-1:0] OCT_NEG_Y = 8'b1010_0110;

  localparam logic [COLOR_W-1:0] OCT_COLOR [MASK_W] = '{
    24'hFF0000, 24'hFFFF00, 24'hFFFFFF, 24'hFF00FF,
    24'h00FFFF, 24'h00FF00, 24'h0000FF, 24'hFF64FF
  };

endpackage

// ----- rtl/core/octant_masked_circle_rasterizer_unit.sv -----
// Top level of the octant masked circle rasterizer.
// Depends on omcr_pkg and octant_masked_circle_rasterizer_unit_defines.svh.
//
// Midpoint circle generator with an octant enable mask. A start beat loads
// the center, radius and mask and gives no pixel. Each step beat on a live
// circle updates x, y and the decision value in the cycle it is accepted and
// parks one step (old x, new y, center, mask) in a result register; from
// there one pixel beat leaves per cycle while out_ready_i is high, lowest
// enabled octant first, with its color, an on-canvas flag, a last-of-step
// marker and the end-of-circle flag. A step therefore yields as many pixel
// beats as its mask has set bits (0 to 8); the next input beat is taken in
// the same cycle the final pixel of the current step is taken, so start
// beats, idle steps and empty-mask steps yield no pixel. Canvas size
// registers are read live; write them only while no pixels are pending.
`include "octant_masked_circle_rasterizer_unit_defines.svh"

module octant_masked_circle_rasterizer_unit
  import omcr_pkg::*;
#(
  parameter int unsigned CoordBits = COORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input item channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic [CENTER_W-1:0]  center_x_i,
  input  logic [CENTER_W-1:0]  center_y_i,
  input  logic [RADIUS_W-1:0]  radius_i,
  input  logic [MASK_W-1:0]    octant_mask_i,
  // pixel result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [PIX_W-1:0] pixel_x_o,
  output logic signed [PIX_W-1:0] pixel_y_o,
  output logic [OCT_W-1:0]     octant_o,
  output logic [COLOR_W-1:0]   pixel_color_o,
  output logic                 on_image_o,
  output logic                 last_of_step_o,
  output logic                 circle_done_o
);

  // Pixel sums carry the wider of center and step plus sign and carry.
  localparam int unsigned SumBits = ((CoordBits > STEP_W) ? CoordBits : STEP_W) + 2;
  localparam int unsigned CmpBits = ((SumBits - 1) > CFG_W) ? (SumBits - 1) : CFG_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] img_w_q, img_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= IMAGE_WIDTH_RST;
      img_h_q <= IMAGE_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  img_w_q <= cfg_data_i;
        REG_IMAGE_HEIGHT: img_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Circle state
  // ---------------------------------------------------------------------------
  logic signed [STEP_W-1:0] step_x_q, step_x_d, step_y_q, step_y_d;
  logic signed [DEC_W-1:0]  dec_q, dec_d;
  logic [CoordBits-1:0]     held_cx_q, held_cx_d, held_cy_q, held_cy_d;
  logic [MASK_W-1:0]        held_mask_q, held_mask_d;
  logic                     active_q, active_d;

  // Result register: one parked step, drained one octant per beat.
  logic signed [STEP_W-1:0] res_x_q, res_y_q;
  logic [CoordBits-1:0]     res_cx_q, res_cy_q;
  logic                     res_done_q;
  logic [MASK_W-1:0]        pend_q, pend_d;

  logic in_fire, out_fire, res_load;
  logic [MASK_W-1:0] sel;

  // Step arithmetic on the current state
  logic                     step_ok, dec_pos, done;
  logic signed [STEP_W-1:0] y_new, x_new;
  logic signed [DEC_W-1:0]  x_ext, y_ext, dec_step;

  assign step_ok = active_q && (step_x_q <= step_y_q);
  assign dec_pos = !dec_q[DEC_W-1];
  assign y_new   = dec_pos ? step_y_q - STEP_W'(1) : step_y_q;
  assign x_new   = step_x_q + STEP_W'(1);
  assign done    = x_new > y_new;
  assign x_ext   = DEC_W'(step_x_q);
  assign y_ext   = DEC_W'(y_new);

  always_comb begin
    if (dec_pos) begin
      dec_step = dec_q + ((x_ext - y_ext) <<< 2) + DEC_ADD_POS;
    end else begin
      dec_step = dec_q + (x_ext <<< 2) + DEC_ADD_NEG;
    end
  end

  // Take a new beat when nothing is parked or the last parked pixel leaves now.
  assign in_ready_o = (pend_q == '0) || (out_fire && ((pend_q & ~sel) == '0));
  assign in_fire    = in_valid_i && in_ready_o;
  assign res_load   = in_fire && (opcode_i == OP_STEP) && step_ok;

  always_comb begin
    step_x_d    = step_x_q;
    step_y_d    = step_y_q;
    dec_d       = dec_q;
    held_cx_d   = held_cx_q;
    held_cy_d   = held_cy_q;
    held_mask_d = held_mask_q;
    active_d    = active_q;
    if (in_fire) begin
      if (opcode_i == OP_START) begin
        held_cx_d   = CoordBits'(center_x_i);
        held_cy_d   = CoordBits'(center_y_i);
        held_mask_d = octant_mask_i;
        step_x_d    = '0;
        step_y_d    = STEP_W'(radius_i);
        dec_d       = DEC_INIT - (DEC_W'(radius_i) << 1);
        active_d    = 1'b1;
      end else if (step_ok) begin
        step_x_d = x_new;
        step_y_d = y_new;
        dec_d    = dec_step;
        active_d = !done;
      end else begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q    <= '0;
      step_y_q    <= '0;
      dec_q       <= '0;
      held_cx_q   <= '0;
      held_cy_q   <= '0;
      held_mask_q <= '0;
      active_q    <= 1'b0;
      pend_q      <= '0;
    end else begin
      step_x_q    <= step_x_d;
      step_y_q    <= step_y_d;
      dec_q       <= dec_d;
      held_cx_q   <= held_cx_d;
      held_cy_q   <= held_cy_d;
      held_mask_q <= held_mask_d;
      active_q    <= active_d;
      pend_q      <= pend_d;
    end
  end

  // Payload of the parked step: plot with the old x and the updated y.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_x_q    <= step_x_q;
      res_y_q    <= y_new;
      res_cx_q   <= held_cx_q;
      res_cy_q   <= held_cy_q;
      res_done_q <= done;
    end
  end

  // Drop the octant just sent; a newly parked step overrides (only legal
  // once the previous step has fully drained).
  always_comb begin
    pend_d = pend_q;
    if (out_fire) begin
      pend_d = pend_q & ~sel;
    end
    if (res_load) begin
      pend_d = held_mask_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel output: lowest pending octant
  // ---------------------------------------------------------------------------
  logic [OCT_W-1:0]          oct;
  logic                      swap, neg_x, neg_y;
  logic signed [STEP_W-1:0]  off_a, off_b;
  logic signed [SumBits-1:0] cx_s, cy_s, a_s, b_s, px, py;

  assign sel = pend_q & (~pend_q + MASK_W'(1));

  always_comb begin
    oct = '0;
    for (int k = 0; k < MASK_W; k++) begin
      if (sel[k]) begin
        oct = oct | OCT_W'(k);
      end
    end
  end

  assign swap  = oct[OCT_W-1];
  assign neg_x = OCT_NEG_X[oct];
  assign neg_y = OCT_NEG_Y[oct];
  assign off_a = swap ? res_y_q : res_x_q;
  assign off_b = swap ? res_x_q : res_y_q;
  assign cx_s  = SumBits'(res_cx_q);
  assign cy_s  = SumBits'(res_cy_q);
  assign a_s   = SumBits'(off_a);
  assign b_s   = SumBits'(off_b);
  assign px    = neg_x ? cx_s - a_s : cx_s + a_s;
  assign py    = neg_y ? cy_s - b_s : cy_s + b_s;

  assign out_valid_o    = (pend_q != '0);
  assign out_fire       = out_valid_o && out_ready_i;
  assign pixel_x_o      = px[PIX_W-1:0];
  assign pixel_y_o      = py[PIX_W-1:0];
  assign octant_o       = oct;
  assign pixel_color_o  = OCT_COLOR[oct];
  assign on_image_o     = !px[SumBits-1] && !py[SumBits-1]
                       && (CmpBits'(px[SumBits-2:0]) < CmpBits'(img_w_q))
                       && (CmpBits'(py[SumBits-2:0]) < CmpBits'(img_h_q));
  assign last_of_step_o = ((pend_q & ~sel) == '0);
  assign circle_done_o  = res_done_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // A beat is only taken over a parked step when its final pixel leaves.
  `OMCR_ASSERT_IMP(a_in_only_on_drain, in_fire && (pend_q != '0), out_fire && last_of_step_o)
  // Within a step the end-of-circle flag holds from pixel to pixel.
  `OMCR_ASSERT_NXT(a_done_steady, out_fire && !last_of_step_o, out_valid_o && (circle_done_o == $past(circle_done_o)))
  // Pixels of a closing step never coexist with a live circle.
  `OMCR_ASSERT_IMP(a_done_inactive, out_valid_o && circle_done_o, !active_q)

endmodule

// ----- tb/sv/tb_octant_masked_circle_rasterizer_unit.sv -----
// Self-checking bench for octant_masked_circle_rasterizer_unit: predicts every pixel beat
// of the midpoint circle stepper and compares it with the block, field by field.
// Depends on omcr_pkg and the rasterizer RTL only.
module tb_octant_masked_circle_rasterizer_unit;
  import omcr_pkg::*;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int HOLD_CYCLES  = 400;   // long receiver stall for back-pressure
  localparam int SETTLE_GAP   = 16;    // cycles to let empty-mask steps finish
  localparam int RANDOM_ITEMS = 71;    // per random phase, four phases

  // Plotting colors per octant, lowest octant first.
  localparam logic [COLOR_W-1:0] OCTANT_RGB [8] = '{
    24'hFF0000, 24'hFFFF00, 24'hFFFFFF, 24'hFF00FF,
    24'h00FFFF, 24'h00FF00, 24'h0000FF, 24'hFF64FF
  };

  typedef struct packed {
    logic                opcode;
    logic [CENTER_W-1:0] cx;
    logic [CENTER_W-1:0] cy;
    logic [RADIUS_W-1:0] radius;
    logic [MASK_W-1:0]   mask;
  } circle_cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
    logic [OCT_W-1:0]   oct;
    logic [COLOR_W-1:0] rgb;
    logic               on_img;
    logic               last;
    logic               done;
  } pixel_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic                opcode_i      = OP_START;
  logic [CENTER_W-1:0] center_x_i    = '0;
  logic [CENTER_W-1:0] center_y_i    = '0;
  logic [RADIUS_W-1:0] radius_i      = '0;
  logic [MASK_W-1:0]   octant_mask_i = '0;

  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [PIX_W-1:0] pixel_x_o;
  logic signed [PIX_W-1:0] pixel_y_o;
  logic [OCT_W-1:0]        octant_o;
  logic [COLOR_W-1:0]      pixel_color_o;
  logic                    on_image_o;
  logic                    last_of_step_o;
  logic                    circle_done_o;

  octant_masked_circle_rasterizer_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .radius_i       (radius_i),
    .octant_mask_i  (octant_mask_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .octant_o       (octant_o),
    .pixel_color_o  (pixel_color_o),
    .on_image_o     (on_image_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predicted circle state, kept at the block's own widths so wraps match.
  logic [CENTER_W-1:0]     org_x, org_y;
  logic [MASK_W-1:0]       held_oct;
  logic signed [STEP_W-1:0] cur_x, cur_y;
  logic signed [DEC_W-1:0]  dec_val;
  logic                    live;
  logic [CFG_W-1:0]        canvas_w, canvas_h;

  circle_cmd_t item_q[$];    // beats waiting for the driver
  pixel_beat_t pixel_q[$];   // pixels the block still owes us

  int errors       = 0;
  int beats_in     = 0;
  int pixels_seen  = 0;
  int circles_seen = 0;
  int settings_run = 0;
  int hold_asked   = 0;
  int cycles       = 0;

  // Apply one accepted input beat to the predicted state and queue the pixels it yields.
  function automatic void advance_circle(input circle_cmd_t c);
    int          col, row, top_k;
    logic        done;
    pixel_beat_t p;
    if (c.opcode == OP_START) begin
      org_x    = c.cx;
      org_y    = c.cy;
      held_oct = c.mask;
      cur_x    = '0;
      cur_y    = {1'b0, c.radius};
      dec_val  = DEC_W'(3 - 2 * int'(c.radius));
      live     = 1'b1;
      return;
    end
    // Steps on a finished or never-started circle are dropped.
    if (!live || cur_x > cur_y) begin
      live = 1'b0;
      return;
    end
    if (dec_val >= 0) begin
      cur_y   = STEP_W'(cur_y - 1);
      dec_val = DEC_W'(dec_val + 4 * (cur_x - cur_y) + 10);
    end else begin
      dec_val = DEC_W'(dec_val + 4 * cur_x + 6);
    end
    top_k = -1;
    for (int k = 0; k < 8; k++) if (held_oct[k]) top_k = k;
    // Plot with the pre-increment x and the updated y.
    for (int k = 0; k < 8; k++) begin
      if (!held_oct[k]) continue;
      case (k)
        0: begin col = int'(org_x) + cur_x; row = int'(org_y) + cur_y; end
        1: begin col = int'(org_x) - cur_x; row = int'(org_y) - cur_y; end
        2: begin col = int'(org_x) + cur_x; row = int'(org_y) - cur_y; end
        3: begin col = int'(org_x) - cur_x; row = int'(org_y) + cur_y; end
        4: begin col = int'(org_x) - cur_y; row = int'(org_y) + cur_x; end
        5: begin col = int'(org_x) - cur_y; row = int'(org_y) - cur_x; end
        6: begin col = int'(org_x) + cur_y; row = int'(org_y) + cur_x; end
        default: begin col = int'(org_x) + cur_y; row = int'(org_y) - cur_x; end
      endcase
      p.px     = col[PIX_W-1:0];
      p.py     = row[PIX_W-1:0];
      p.oct    = k[OCT_W-1:0];
      p.rgb    = OCTANT_RGB[k];
      p.on_img = col >= 0 && row >= 0 && col < int'(canvas_w) && row < int'(canvas_h);
      p.last   = (k == top_k);
      pixel_q.push_back(p);
    end
    cur_x = STEP_W'(cur_x + 1);
    done  = cur_x > cur_y;
    if (done) live = 1'b0;
    // The end flag is known only after x advances; patch this step's pixels.
    for (int i = pixel_q.size() - 1; i >= 0 && top_k >= 0; i--) begin
      pixel_q[i].done = done;
      if (pixel_q[i].oct == OCT_W'(0) || (i > 0 && pixel_q[i-1].last)) break;
    end
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      errors++;
    end
  endfunction

  function automatic circle_cmd_t make_cmd(input logic op, input int cx, input int cy,
                                           input int r, input int m);
    circle_cmd_t c;
    c.opcode = op;
    c.cx     = cx[CENTER_W-1:0];
    c.cy     = cy[CENTER_W-1:0];
    c.radius = r[RADIUS_W-1:0];
    c.mask   = m[MASK_W-1:0];
    return c;
  endfunction

  function automatic void queue_start(input int cx, input int cy, input int r, input int m);
    item_q.push_back(make_cmd(OP_START, cx, cy, r, m));
  endfunction

  // Step beats carry junk in the unused fields.
  function automatic void queue_steps(input int n);
    for (int i = 0; i < n; i++)
      item_q.push_back(make_cmd(OP_STEP, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 511), $urandom_range(0, 255)));
  endfunction

  // Mostly well-formed circles (start then a run of steps, often cut short by a
  // restart), with some raw noise beats mixed in.
  function automatic void queue_random_circles(input int budget);
    int left, r, m, n;
    left = budget;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 8) begin
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 24);
        case ($urandom_range(0, 7))
          0:       m = 0;
          1, 2:    m = 8'hFF;
          default: m = $urandom_range(1, 255);
        endcase
        queue_start($urandom_range(0, 1023), $urandom_range(0, 1023), r, m);
        n = r * 3 / 4 + $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) n = $urandom_range(0, n);
        if (n > 40) n = 40;
        if (n > left - 1) n = left - 1;
        queue_steps(n);
        left -= n + 1;
      end else begin
        for (int i = $urandom_range(1, 3); i > 0 && left > 0; i--) begin
          item_q.push_back(make_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                                    $urandom_range(0, 1023), $urandom_range(0, 511),
                                    $urandom_range(0, 255)));
          left--;
        end
      end
    end
  endfunction

  // Write one canvas register; only called while nothing is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) canvas_w = value[CFG_W-1:0];
    else                        canvas_h = value[CFG_W-1:0];
  endtask

  task automatic set_canvas(input int w, input int h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    settings_run++;
  endtask

  // Hold the sender until every beat is taken and every pixel is back, then
  // give trailing empty-mask steps time to retire.
  task automatic settle();
    while (item_q.size() != 0 || in_valid_i || pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_GAP) @(posedge clk_i);
  endtask

  // Driver: offer queued beats in bursts separated by random gaps.
  circle_cmd_t cur_cmd;
  int burst_left, gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        advance_circle(cur_cmd);
        beats_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (item_q.size() != 0) begin
          cur_cmd = item_q.pop_front();
          opcode_i      <= cur_cmd.opcode;
          center_x_i    <= cur_cmd.cx;
          center_y_i    <= cur_cmd.cy;
          radius_i      <= cur_cmd.radius;
          octant_mask_i <= cur_cmd.mask;
          in_valid_i    <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // Occasionally run a long unbroken burst.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: switch between stall patterns; serve long hold-offs on request.
  int hold_served, hold_left, ready_mode, mode_left, ready_phase;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_served = 0;
      hold_left   = 0;
      mode_left   = 0;
      ready_phase = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      ready_phase++;
      case (ready_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= (ready_phase % 4) != 3;
        default: out_ready_i <= $urandom_range(0, 4) == 0;
      endcase
    end
  end

  // Monitor: compare each accepted pixel beat with the oldest prediction.
  pixel_beat_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      pixels_seen++;
      if (last_of_step_o && circle_done_o) circles_seen++;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel beat, expected none, actual x=%0d y=%0d octant=%0d",
                 $time, pixel_x_o, pixel_y_o, octant_o);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        check_field("pixel_x", 32'(want.px), 32'($unsigned(pixel_x_o)));
        check_field("pixel_y", 32'(want.py), 32'($unsigned(pixel_y_o)));
        check_field("octant", 32'(want.oct), 32'(octant_o));
        check_field("pixel_color", 32'(want.rgb), 32'(pixel_color_o));
        check_field("on_image", 32'(want.on_img), 32'(on_image_o));
        check_field("last_of_step", 32'(want.last), 32'(last_of_step_o));
        check_field("circle_done", 32'(want.done), 32'(circle_done_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d pixels still owed",
               $time, cycles, pixel_q.size());
      $display("octant_masked_circle_rasterizer_unit test failed");
      $finish;
    end
  end

  initial begin
    org_x    = '0;
    org_y    = '0;
    held_oct = '0;
    cur_x    = '0;
    cur_y    = '0;
    dec_val  = '0;
    live     = 1'b0;
    canvas_w = IMAGE_WIDTH_RST;
    canvas_h = IMAGE_HEIGHT_RST;
    settings_run = 1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset canvas: idle step, radius 0 at the origin (negative
    // coordinates, y drops to -1), step after the end, far corner with full
    // radius, empty mask, restart mid-circle, sparse masks.
    queue_steps(1);
    queue_start(0, 0, 0, 8'hFF);
    queue_steps(2);
    queue_start(1023, 1023, 511, 8'hFF);
    queue_steps(3);
    queue_start(10, 10, 2, 8'h00);
    queue_steps(3);
    queue_start(299, 0, 4, 8'h5A);
    queue_steps(1);
    queue_start(0, 299, 2, 8'hA5);
    queue_steps(3);
    queue_start(150, 150, 1, 8'h81);
    queue_steps(2);
    settle();

    // Zero-size canvas: nothing lands on the image.
    set_canvas(0, 0);
    queue_start(5, 5, 3, 8'hFF);
    queue_steps(3);
    settle();

    // Random phases over several canvas settings; stall the receiver for a
    // long stretch in the first one so the block backs up onto its input.
    set_canvas(2048, 2048);
    hold_asked++;
    queue_random_circles(RANDOM_ITEMS);
    settle();

    set_canvas(4095, 1);
    queue_random_circles(RANDOM_ITEMS);
    settle();

    set_canvas(1, 4095);
    queue_random_circles(RANDOM_ITEMS);
    settle();

    set_canvas($urandom_range(1, 2048), $urandom_range(1, 2048));
    queue_random_circles(RANDOM_ITEMS);
    settle();

    $display("Run covered %0d input beats and %0d pixel beats (%0d circle ends)",
             beats_in, pixels_seen, circles_seen);
    $display("over %0d canvas settings, with bursts, stalls and a long output hold-off.",
             settings_run);
    if (errors == 0) begin
      $display("octant_masked_circle_rasterizer_unit test passed");
    end else begin
      $display("%0d mismatches found", errors);
      $display("octant_masked_circle_rasterizer_unit test failed");
    end
    $finish;
  end

endmodule

// ----- octant_masked_circle_rasterizer_unit.f -----
+incdir+rtl/core
rtl/core/omcr_pkg.sv
rtl/core/octant_masked_circle_rasterizer_unit.sv
tb/sv/tb_octant_masked_circle_rasterizer_unit.sv
